// ===== rtl/gamepad_report_to_key_events_macros.svh =====
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef GAMEPAD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`define GAMEPAD_REPORT_TO_KEY_EVENTS_MACROS_SVH

// same-cycle implication
`define GPK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gpk_pkg.sv =====
`default_nettype none

package gpk_pkg;

	localparam int KEY_WIDTH    = 32;
	localparam int BUTTON_COUNT = 4;
	localparam int TABLE_DEPTH  = 39;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int EV_COUNT     = 15;
	localparam int PADDR_W      = 4;

	localparam logic [3:0] BUTTON_MASK = 4'((1 << BUTTON_COUNT) - 1);

	localparam logic [3:0] HAT_CENTER = 4'd8;

	// stick headings, up then clockwise, centered last
	localparam logic [3:0] HDG_N  = 4'd0;
	localparam logic [3:0] HDG_NE = 4'd1;
	localparam logic [3:0] HDG_E  = 4'd2;
	localparam logic [3:0] HDG_SE = 4'd3;
	localparam logic [3:0] HDG_S  = 4'd4;
	localparam logic [3:0] HDG_SW = 4'd5;
	localparam logic [3:0] HDG_W  = 4'd6;
	localparam logic [3:0] HDG_NW = 4'd7;
	localparam logic [3:0] HDG_C  = 4'd8;

	// key table layout
	localparam logic [IDX_W-1:0] IDX_BUTTON  = IDX_W'(9);
	localparam logic [IDX_W-1:0] IDX_BUMPER  = IDX_W'(13);
	localparam logic [IDX_W-1:0] IDX_TRIGGER = IDX_W'(15);
	localparam logic [IDX_W-1:0] IDX_STICK   = IDX_W'(17);
	localparam logic [IDX_W-1:0] IDX_PRESS   = IDX_W'(35);
	localparam logic [IDX_W-1:0] IDX_OPTION  = IDX_W'(37);
	localparam int               STICK_SPAN  = 9;

	// event slots in emit order
	localparam int EV_HAT      = 0;
	localparam int EV_BUTTON   = 1;
	localparam int EV_SIDE     = 5;
	localparam int SIDE_SPAN   = 5;
	localparam int EV_BUMPER   = 0;
	localparam int EV_TRIGGER  = 1;
	localparam int EV_STICK    = 2;
	localparam int EV_PRESS    = 3;
	localparam int EV_OPTION   = 4;

	// side_bits positions, left then right
	localparam int SB_BUMPER  = 0;
	localparam int SB_TRIGGER = 2;
	localparam int SB_OPTION  = 4;
	localparam int SB_PRESS   = 6;

	// register map and reset values
	localparam logic [PADDR_W-1:0] ADDR_AXIS_CENTER = PADDR_W'(0);
	localparam logic [PADDR_W-1:0] ADDR_RADIUS_SQ   = PADDR_W'(4);
	localparam logic [PADDR_W-1:0] ADDR_DEAD_ZONE   = PADDR_W'(8);

	localparam logic [7:0]  AXIS_CENTER_RST = 8'd127;
	localparam logic [15:0] RADIUS_SQ_RST   = 16'd3276;
	localparam logic [7:0]  DEAD_ZONE_RST   = 8'd40;

	typedef struct packed {
		logic [7:0]  axis_center;
		logic [15:0] radius_sq_threshold;
		logic [7:0]  axis_dead_zone;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
		logic [3:0]  hat;
		logic [3:0]  face_buttons;
		logic [7:0]  side_bits;
		logic [5:0]  table_index;
		logic [31:0] table_key;
	} rpt_t;

	typedef struct packed {
		logic [31:0] key_code;
		logic        last_event;
	} evt_t;

	typedef struct packed {
		logic [EV_COUNT-1:0]            mask;
		logic [EV_COUNT-1:0][IDX_W-1:0] idx;
	} ev_list_t;

	typedef struct packed {
		logic                 we;
		logic [IDX_W-1:0]     idx;
		logic [KEY_WIDTH-1:0] key;
	} tbl_wr_t;

	typedef struct packed {
		logic free;
		logic busy;
	} ser_stat_t;

endpackage

`default_nettype wire

// ===== rtl/gamepad_report_to_key_events.sv =====
// channel | role          | handshake            | beat payload
// --------+---------------+----------------------+-------------------------------
// rpt     | report in     | rpt_valid/rpt_ready  | rpt_t: report or key table write
// evt     | key event out | evt_valid/evt_ready  | evt_t: key_code, last_event
// apb     | config        | psel/penable/pready  | axis_center, radius_sq, dead zone
//
// a report is held in the input register, then its events leave one per cycle
// while evt_ready holds (up to 15 per report), a rate set by the single key
// table read port; a key table write beat produces no events
// an event passes s1, the pending mask, the table read and the output register
// reset clears the key table valid bits and returns the previous report state and config to their reset values
// a stalled evt side backs up through the read stage into rpt_ready
`default_nettype none

`include "gamepad_report_to_key_events_macros.svh"

module gamepad_report_to_key_events (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [gpk_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          rpt_valid,
	output logic                               rpt_ready,
	input  wire gpk_pkg::rpt_t                 rpt,
	output logic                               evt_valid,
	input  wire logic                          evt_ready,
	output gpk_pkg::evt_t                      evt
);
	import gpk_pkg::*;

	cfg_t      cfg_q;
	logic      cfg_wr;

	rpt_t      rpt_s1;
	logic      s1_valid_q;
	logic      s1_adv;

	ev_list_t  ev;
	tbl_wr_t   tbl;
	ser_stat_t ser_stat;

	// ---------------- configuration port ----------------
	// zero wait state, write lands on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_center         <= AXIS_CENTER_RST;
			cfg_q.radius_sq_threshold <= RADIUS_SQ_RST;
			cfg_q.axis_dead_zone      <= DEAD_ZONE_RST;
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_AXIS_CENTER: cfg_q.axis_center         <= pwdata[7:0];
				ADDR_RADIUS_SQ:   cfg_q.radius_sq_threshold <= pwdata[15:0];
				ADDR_DEAD_ZONE:   cfg_q.axis_dead_zone      <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_AXIS_CENTER: prdata = 32'(cfg_q.axis_center);
			ADDR_RADIUS_SQ:   prdata = 32'(cfg_q.radius_sq_threshold);
			ADDR_DEAD_ZONE:   prdata = 32'(cfg_q.axis_dead_zone);
			default:          prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// an item leaves s1 once the serializer has handed out its last pending read,
	// so the key table is only written after earlier reports have read it
	assign s1_adv    = s1_valid_q && ser_stat.free;
	assign rpt_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rpt_ready) begin
			s1_valid_q <= rpt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_valid && rpt_ready) begin
			rpt_s1 <= rpt;
		end
	end

	// ---------------- event detection ----------------
	// previous report state moves only when a controller report is taken
	gpk_event_detect u_detect (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.rpt   (rpt_s1),
		.update(s1_adv && !rpt_s1.mode),
		.ev    (ev)
	);

	// key table write beat, masked to the stored key width
	assign tbl.we  = s1_adv && rpt_s1.mode;
	assign tbl.idx = rpt_s1.table_index;
	assign tbl.key = rpt_s1.table_key[KEY_WIDTH-1:0];

	// ---------------- event serializer and key table ----------------
	gpk_event_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_adv && !rpt_s1.mode),
		.ev       (ev),
		.tbl      (tbl),
		.evt_ready(evt_ready),
		.evt_valid(evt_valid),
		.evt      (evt),
		.stat     (ser_stat)
	);

	// ---------------- checks ----------------
	// a beat that is not the last of its report must have more work behind it
	`GPK_ASSERT_NOW(a_more_after_not_last, evt_valid && evt_ready && !evt.last_event, ser_stat.busy, "event beat without last flag but nothing pending")
	// a new output beat comes only from a table read in flight
	`GPK_ASSERT_NOW(a_out_from_read, $rose(evt_valid), $past(ser_stat.busy), "output appeared with serializer idle")
	// a table write never lands while reads of an earlier report are still pending
	`GPK_ASSERT_NEXT(a_write_after_drain, tbl.we, !($past(ser_stat.busy) && !$past(ser_stat.free)), "key table written under pending reads")

endmodule

`default_nettype wire

// ===== rtl/gpk_ram.sv =====
`default_nettype none

module gpk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 39
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gpk_stick_dir.sv =====
`default_nettype none

module gpk_stick_dir (
	input  wire gpk_pkg::cfg_t cfg,
	input  wire logic [7:0]    ax,
	input  wire logic [7:0]    ay,
	output logic      [3:0]    dir
);
	import gpk_pkg::*;

	logic [8:0]  dx, dy;
	logic [7:0]  mx, my;
	logic [15:0] sqx, sqy;
	logic [16:0] r2;
	logic        xp, xn, yp, yn;

	// offsets from rest as sign and magnitude
	assign dx = {1'b0, ax} - {1'b0, cfg.axis_center};
	assign dy = {1'b0, ay} - {1'b0, cfg.axis_center};
	assign mx = dx[8] ? 8'(-dx) : dx[7:0];
	assign my = dy[8] ? 8'(-dy) : dy[7:0];

	assign sqx = mx * mx;
	assign sqy = my * my;
	assign r2  = {1'b0, sqx} + {1'b0, sqy};

	assign xp = !dx[8] && (mx > cfg.axis_dead_zone);
	assign xn =  dx[8] && (mx > cfg.axis_dead_zone);
	assign yp = !dy[8] && (my > cfg.axis_dead_zone);
	assign yn =  dy[8] && (my > cfg.axis_dead_zone);

	always_comb begin
		if (r2 <= {1'b0, cfg.radius_sq_threshold}) begin
			dir = HDG_C;
		end else begin
			// small y is up
			unique case ({xp, xn, yp, yn})
				4'b1000: dir = HDG_E;
				4'b1001: dir = HDG_NE;
				4'b0001: dir = HDG_N;
				4'b0101: dir = HDG_NW;
				4'b0100: dir = HDG_W;
				4'b0110: dir = HDG_SW;
				4'b0010: dir = HDG_S;
				4'b1010: dir = HDG_SE;
				default: dir = HDG_C;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gpk_event_detect.sv =====
`default_nettype none

module gpk_event_detect (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gpk_pkg::cfg_t     cfg,
	input  wire gpk_pkg::rpt_t     rpt,
	input  wire logic              update,
	output gpk_pkg::ev_list_t      ev
);
	import gpk_pkg::*;

	logic [7:0] prev_lx_q, prev_ly_q, prev_rx_q, prev_ry_q;
	logic [3:0] prev_hat_q;
	logic [3:0] prev_face_q;
	logic [7:0] prev_side_q;

	logic [3:0]      hat_c;
	logic [3:0]      face_rise;
	logic [7:0]      side_rise;
	logic [1:0][3:0] new_dir, old_dir;

	gpk_stick_dir u_new_left (.cfg(cfg), .ax(rpt.left_x), .ay(rpt.left_y), .dir(new_dir[0]));
	gpk_stick_dir u_new_right (.cfg(cfg), .ax(rpt.right_x), .ay(rpt.right_y), .dir(new_dir[1]));
	gpk_stick_dir u_prev_left (.cfg(cfg), .ax(prev_lx_q), .ay(prev_ly_q), .dir(old_dir[0]));
	gpk_stick_dir u_prev_right (.cfg(cfg), .ax(prev_rx_q), .ay(prev_ry_q), .dir(old_dir[1]));

	// hat codes above centered fold onto centered
	assign hat_c     = (rpt.hat > HAT_CENTER) ? HAT_CENTER : rpt.hat;
	assign face_rise = rpt.face_buttons & ~prev_face_q & BUTTON_MASK;
	assign side_rise = rpt.side_bits & ~prev_side_q;

	always_comb begin
		int base;
		ev = '0;
		ev.mask[EV_HAT] = (hat_c != prev_hat_q);
		ev.idx[EV_HAT]  = IDX_W'(hat_c);
		for (int i = 0; i < 4; i++) begin
			ev.mask[EV_BUTTON + i] = face_rise[i];
			ev.idx[EV_BUTTON + i]  = IDX_BUTTON + IDX_W'(i);
		end
		for (int s = 0; s < 2; s++) begin
			base = EV_SIDE + s * SIDE_SPAN;
			ev.mask[base + EV_BUMPER]  = side_rise[SB_BUMPER + s];
			ev.idx[base + EV_BUMPER]   = IDX_BUMPER + IDX_W'(s);
			ev.mask[base + EV_TRIGGER] = side_rise[SB_TRIGGER + s];
			ev.idx[base + EV_TRIGGER]  = IDX_TRIGGER + IDX_W'(s);
			ev.mask[base + EV_STICK]   = (new_dir[s] != old_dir[s]);
			ev.idx[base + EV_STICK]    = IDX_STICK + IDX_W'(s * STICK_SPAN)
				+ IDX_W'(new_dir[s]);
			ev.mask[base + EV_PRESS]   = side_rise[SB_PRESS + s];
			ev.idx[base + EV_PRESS]    = IDX_PRESS + IDX_W'(s);
			ev.mask[base + EV_OPTION]  = side_rise[SB_OPTION + s];
			ev.idx[base + EV_OPTION]   = IDX_OPTION + IDX_W'(s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lx_q   <= '0;
			prev_ly_q   <= '0;
			prev_rx_q   <= '0;
			prev_ry_q   <= '0;
			prev_hat_q  <= HAT_CENTER;
			prev_face_q <= '0;
			prev_side_q <= '0;
		end else if (update) begin
			prev_lx_q   <= rpt.left_x;
			prev_ly_q   <= rpt.left_y;
			prev_rx_q   <= rpt.right_x;
			prev_ry_q   <= rpt.right_y;
			prev_hat_q  <= hat_c;
			prev_face_q <= rpt.face_buttons;
			prev_side_q <= rpt.side_bits;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gpk_event_serializer.sv =====
`default_nettype none

module gpk_event_serializer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire gpk_pkg::ev_list_t ev,
	input  wire gpk_pkg::tbl_wr_t  tbl,
	input  wire logic              evt_ready,
	output logic                   evt_valid,
	output gpk_pkg::evt_t          evt,
	output gpk_pkg::ser_stat_t     stat
);
	import gpk_pkg::*;

	logic [EV_COUNT-1:0]            pend_mask_q;
	logic [EV_COUNT-1:0][IDX_W-1:0] pend_idx_q;
	logic [EV_COUNT-1:0]            pick, rest;
	logic [IDX_W-1:0]               pick_idx;
	logic                           issue, move, tbl_we;
	logic                           rd_valid_s2, rd_hit_s2, rd_last_s2;
	logic [TABLE_DEPTH-1:0]         tv_q;
	logic [KEY_WIDTH-1:0]           rdata;
	logic                           evt_valid_q;
	evt_t                           evt_q;

	// lowest pending slot goes first
	assign pick = pend_mask_q & (~pend_mask_q + EV_COUNT'(1));
	assign rest = pend_mask_q & ~pick;

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < EV_COUNT; i++) begin
			pick_idx = pick_idx | (pend_idx_q[i] & {IDX_W{pick[i]}});
		end
	end

	assign move  = rd_valid_s2 && (!evt_valid_q || evt_ready);
	assign issue = (|pend_mask_q) && (!rd_valid_s2 || move);

	assign stat.free = !(|pend_mask_q) || (issue && !(|rest));
	assign stat.busy = (|pend_mask_q) || rd_valid_s2;

	assign tbl_we = tbl.we && (tbl.idx < IDX_W'(TABLE_DEPTH));

	gpk_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl.idx),
		.wdata(tbl.key),
		.re   (issue),
		.raddr(pick_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
			rd_valid_s2 <= 1'b0;
			evt_valid_q <= 1'b0;
			tv_q        <= '0;
		end else begin
			if (load) begin
				pend_mask_q <= ev.mask;
			end else if (issue) begin
				pend_mask_q <= rest;
			end
			rd_valid_s2 <= issue || (rd_valid_s2 && !move);
			evt_valid_q <= move || (evt_valid_q && !evt_ready);
			if (tbl_we) begin
				tv_q[tbl.idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pend_idx_q <= ev.idx;
		end
		if (issue) begin
			rd_hit_s2  <= tv_q[pick_idx];
			rd_last_s2 <= !(|rest);
		end
		if (move) begin
			// never-written entries read as no key
			evt_q.key_code   <= rd_hit_s2 ? 32'(rdata) : '0;
			evt_q.last_event <= rd_last_s2;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

endmodule

`default_nettype wire
